[rtl/itwc_pkg.sv]
// ----------------------------------------------------------------------------
// itwc_pkg
// Shared types and constants for the wraparound millisecond interval timer.
// ----------------------------------------------------------------------------
package itwc_pkg;

  // Period value that marks the timer as disabled.
  localparam logic [31:0] DISABLE_VAL   = 32'h7FFF_FFFF;
  // Period value that means no wait.
  localparam logic [31:0] NOWAIT_VAL    = 32'h0000_0000;
  // Catch-up is only considered for amounts below half the disable value.
  localparam logic [31:0] CATCHUP_LIMIT = DISABLE_VAL / 32'd2;
  // Reciprocal of three, scaled by 2^33, for the divide-by-three multiply.
  localparam logic [31:0] RECIP3        = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHIFT  = 33;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_SET          = 3'd1,
    CMD_RESTART      = 3'd2,
    CMD_INCR         = 3'd3,
    CMD_INCR_CATCHUP = 3'd4
  } itwc_cmd_t;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] amount;
  } itwc_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] elapsed;
    logic signed [31:0] expired_by;
    logic [30:0]        remaining;
    logic               timing;
    logic               disabled;
  } itwc_out_t;

  // Registered command with its precomputed catch-up threshold.
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] amount;
    logic signed [31:0] third;      // (2 * amount) / 3, truncated toward zero
    logic               catchup_ok; // amount below the catch-up limit
  } itwc_prep_t;

endpackage

[rtl/itwc_in_stage.sv]
// ----------------------------------------------------------------------------
// itwc_in_stage
// Input register. Takes a command transaction, computes the catch-up
// threshold (2 * amount) / 3 and holds both until the core consumes them.
// ----------------------------------------------------------------------------
module itwc_in_stage
  import itwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  itwc_in_t   in_data,
  input  logic       stage_take,
  output logic       stage_valid,
  output itwc_prep_t stage_data
);

  logic        valid_r;
  logic        valid_nxt;
  itwc_prep_t  data_r;
  itwc_prep_t  data_nxt;

  logic        neg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [30:0] quo;
  logic [32:0] quo_x3;
  logic [31:0] rem_full;
  logic [31:0] two_thirds;

  // The register may load when empty or when its content moves on.
  assign in_ready = !valid_r || stage_take;

  // Magnitude of amount; the most negative value maps to 2^31 correctly.
  assign neg = in_data.amount[31];
  assign mag = neg ? (32'd0 - in_data.amount) : in_data.amount;

  // floor(mag / 3) by reciprocal multiply, then the remainder.
  assign prod     = 64'(mag) * 64'(RECIP3);
  assign quo      = prod[RECIP3_SHIFT+30:RECIP3_SHIFT];
  assign quo_x3   = {1'b0, quo, 1'b0} + {2'b00, quo};
  assign rem_full = mag - quo_x3[31:0];

  // floor(2 * mag / 3) = 2 * floor(mag / 3) + (remainder is two).
  assign two_thirds = {quo, 1'b0} + {31'd0, (rem_full[1:0] == 2'd2)};

  always_comb begin
    data_nxt            = data_r;
    data_nxt.command    = in_data.command;
    data_nxt.amount     = in_data.amount;
    data_nxt.third      = neg ? (32'd0 - two_thirds) : two_thirds;
    data_nxt.catchup_ok = (in_data.amount < $signed(CATCHUP_LIMIT));
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign stage_valid = valid_r;
  assign stage_data  = data_r;

endmodule

[rtl/itwc_core.sv]
// ----------------------------------------------------------------------------
// itwc_core
// Timer state (now, start, period). Applies one command per cycle while fire
// is high and derives the result fields from the updated state.
// ----------------------------------------------------------------------------
module itwc_core
  import itwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  itwc_prep_t cmd_data,
  output itwc_out_t  result
);

  logic [31:0] now_r, now_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] period_r, period_nxt;

  logic [31:0] old_expired;
  logic        behind;
  logic        incr_as_set;
  logic [31:0] deadline;
  logic [31:0] to_go;
  logic        dis;

  // Expired-by value of the current state, used by catch-up.
  assign old_expired = (period_r == DISABLE_VAL) ? DISABLE_VAL
                       : (now_r - (start_r + period_r));
  assign behind      = cmd_data.catchup_ok &&
                       ($signed(old_expired) > cmd_data.third);
  assign incr_as_set = (period_r == DISABLE_VAL) || (period_r == NOWAIT_VAL);

  // Next state selected by command; unused codes hold the state.
  always_comb begin
    now_nxt    = now_r;
    start_nxt  = start_r;
    period_nxt = period_r;
    unique case (itwc_cmd_t'(cmd_data.command))
      CMD_TICK: begin
        now_nxt = now_r + 32'd1;
      end
      CMD_SET: begin
        start_nxt  = now_r;
        period_nxt = cmd_data.amount;
      end
      CMD_RESTART: begin
        start_nxt = now_r;
      end
      CMD_INCR, CMD_INCR_CATCHUP: begin
        if ((cmd_data.command == CMD_INCR_CATCHUP && behind) || incr_as_set) begin
          start_nxt  = now_r;
          period_nxt = cmd_data.amount;
        end else if (cmd_data.amount == DISABLE_VAL) begin
          period_nxt = DISABLE_VAL;
        end else begin
          period_nxt = period_r + cmd_data.amount;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      start_r  <= '0;
      period_r <= '0;
    end else if (fire) begin
      now_r    <= now_nxt;
      start_r  <= start_nxt;
      period_r <= period_nxt;
    end
  end

  // Result fields from the updated state.
  assign dis      = (period_nxt == DISABLE_VAL);
  assign deadline = start_nxt + period_nxt;
  assign to_go    = deadline - now_nxt;

  always_comb begin
    result            = '0;
    result.elapsed    = now_nxt - start_nxt;
    result.disabled   = dis;
    if (dis) begin
      result.expired_by = DISABLE_VAL;
      result.remaining  = DISABLE_VAL[30:0];
      result.timing     = 1'b1;
    end else begin
      result.expired_by = now_nxt - deadline;
      result.remaining  = to_go[31] ? 31'd0 : to_go[30:0];
      result.timing     = !to_go[31] && (to_go != 32'd0);
    end
  end

endmodule

[rtl/interval_timer_with_catchup.sv]
// ----------------------------------------------------------------------------
// interval_timer_with_catchup
// Wraparound millisecond interval timer with tick, set, restart, increment
// and catch-up increment commands; one result per command.
// ----------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction. The block
// takes one command per clock cycle while results are taken: a command sits in
// the input register, the timer state and the output register are updated
// together when the output register is empty or being drained, and the result
// is held in the output register until taken. Throughput is set by the single
// state update path (adder, compare and select) and by the output handshake
// only; the divide by three for catch-up is a reciprocal multiply done as the
// command enters the input register.
module interval_timer_with_catchup
  import itwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  itwc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output itwc_out_t out_data
);

  logic       stage_valid;
  itwc_prep_t stage_data;
  logic       stage_take;
  logic       fire;
  itwc_out_t  result;

  logic       out_valid_r, out_valid_nxt;
  itwc_out_t  out_data_r;

  // Output register can load when empty or being drained.
  assign stage_take = !out_valid_r || out_ready;
  assign fire       = stage_valid && stage_take;

  itwc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .stage_take (stage_take),
    .stage_valid(stage_valid),
    .stage_data (stage_data)
  );

  itwc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .cmd_data(stage_data),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stage_take) begin
      out_valid_nxt = stage_valid;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/itwc_checker.sv]
// ----------------------------------------------------------------------------
// itwc_checker
// Port-level checks for the interval timer, bound to the top level.
// ----------------------------------------------------------------------------
module itwc_checker
  import itwc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input itwc_out_t out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A disabled timer reports the sentinel values and keeps timing.
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.disabled |->
      out_data.expired_by == $signed(DISABLE_VAL) &&
      out_data.remaining == DISABLE_VAL[30:0] && out_data.timing)
    else $error("disabled result fields wrong");

  // Timing flag follows the remaining time when enabled.
  a_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.disabled |-> out_data.timing == (out_data.remaining != 31'd0))
    else $error("timing flag inconsistent");

  // While still timing, expired-by is the negated remaining time.
  a_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.disabled && out_data.timing |->
      out_data.expired_by == (32'sd0 - $signed({1'b0, out_data.remaining})))
    else $error("expired_by disagrees with remaining");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind interval_timer_with_catchup itwc_checker u_itwc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wraparound millisecond interval timer. Command
// transactions go in through a bursty sender, and results are taken by a
// receiver that stalls. A behavioral timer model predicts every result, and
// the monitor checks each result field by field against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import itwc_pkg::*;

  // Command codes that the block does not decode.
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1025;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Receiver stall patterns.
  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  itwc_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  itwc_out_t out_data;

  interval_timer_with_catchup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Commands waiting to be sent and timer reports waiting to be seen.
  itwc_in_t  command_q[$];
  itwc_out_t timer_reports_q[$];
  itwc_out_t report_head;

  // Timer model state; it matches the block right after reset.
  logic [31:0] tmr_now    = '0;
  logic [31:0] tmr_start  = '0;
  logic [31:0] tmr_period = '0;

  int errors          = 0;
  int results_checked = 0;
  int catchup_jumps   = 0;
  int disabled_seen   = 0;
  int timed_out_seen  = 0;
  int cmd_seen[8]     = '{default: 0};
  int cycle_count     = 0;

  int       gap_left    = 0;
  int       burst_left  = 1;
  int       stall_phase = 0;
  rx_mode_t stall_mode  = RX_STREAM;

  // How far the current time lies past the deadline; the disable value when off.
  function automatic longint timer_overrun();
    logic [31:0] lag;
    lag = tmr_now - (tmr_start + tmr_period);
    if (tmr_period == DISABLE_VAL) return longint'(DISABLE_VAL);
    return longint'($signed(lag));
  endfunction

  function automatic void timer_start(logic [31:0] amt);
    tmr_start  = tmr_now;
    tmr_period = amt;
  endfunction

  // A stopped or no-wait timer restarts; otherwise the period grows.
  function automatic void timer_stretch(logic [31:0] amt);
    if (tmr_period == DISABLE_VAL || tmr_period == NOWAIT_VAL) timer_start(amt);
    else if (amt == DISABLE_VAL) tmr_period = DISABLE_VAL;
    else tmr_period = tmr_period + amt;
  endfunction

  // Apply one command to the model and return the report that follows it.
  function automatic itwc_out_t timer_apply(itwc_in_t item);
    itwc_out_t   rep;
    longint      amt_s;
    logic [31:0] left;
    amt_s = longint'(item.amount);
    case (item.command)
      CMD_TICK:    tmr_now = tmr_now + 32'd1;
      CMD_SET:     timer_start(item.amount);
      CMD_RESTART: tmr_start = tmr_now;
      CMD_INCR:    timer_stretch(item.amount);
      CMD_INCR_CATCHUP: begin
        // Jump to a fresh start when too far behind for this step.
        if (amt_s < longint'(CATCHUP_LIMIT) && timer_overrun() > (amt_s * 2) / 3) begin
          timer_start(item.amount);
          catchup_jumps++;
        end else begin
          timer_stretch(item.amount);
        end
      end
      default: ;
    endcase
    rep.disabled = (tmr_period == DISABLE_VAL);
    left = tmr_start + tmr_period - tmr_now;
    if (rep.disabled) rep.remaining = 31'(DISABLE_VAL);
    else if (left[31]) rep.remaining = '0;
    else rep.remaining = left[30:0];
    rep.timing     = (rep.remaining != '0);
    rep.elapsed    = tmr_now - tmr_start;
    rep.expired_by = 32'(timer_overrun());
    if (rep.disabled) disabled_seen++;
    if (!rep.timing) timed_out_seen++;
    return rep;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic add_cmd(logic [2:0] cmd, logic [31:0] amt);
    itwc_in_t item;
    item.command = cmd;
    item.amount  = amt;
    command_q.push_back(item);
  endtask

  // Mostly short periods so deadlines pass within a few ticks.
  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 19);
    if (r <= 10) return 32'($urandom_range(0, 12));
    if (r <= 12) return 32'd0 - 32'($urandom_range(1, 12));
    if (r == 13) return DISABLE_VAL;
    if (r == 14) return CATCHUP_LIMIT + 32'($urandom_range(0, 2)) - 32'd1;
    if (r == 15) return NOWAIT_VAL;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_command(bit noisy);
    int r;
    if (noisy) return 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_TICK;
    if (r < 53) return CMD_SET;
    if (r < 60) return CMD_RESTART;
    if (r < 75) return CMD_INCR;
    if (r < 96) return CMD_INCR_CATCHUP;
    return 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
  endfunction

  // One episode: arm the timer, then let time run while it is adjusted.
  // A few episodes are pure noise with any code and any amount.
  task automatic add_episode();
    int len;
    bit noisy;
    len   = $urandom_range(4, 30);
    noisy = ($urandom_range(0, 9) == 0);
    if (!noisy) add_cmd(CMD_SET, pick_period());
    for (int i = 0; i < len; i++) add_cmd(pick_command(noisy), noisy ? $urandom : pick_period());
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    // Directed part: reset state, catch-up jump and non-jump, disable paths,
    // limit of the catch-up range, extreme amounts and the unused codes.
    add_cmd(CMD_TICK, 32'h8000_0000);
    add_cmd(CMD_INCR_CATCHUP, NOWAIT_VAL);
    add_cmd(CMD_SET, 32'd1);
    repeat (3) add_cmd(CMD_TICK, 32'hFFFF_FFFF);
    add_cmd(CMD_INCR_CATCHUP, 32'd2);
    add_cmd(CMD_INCR_CATCHUP, 32'd3);
    add_cmd(CMD_INCR, 32'hFFFF_FFFE);
    add_cmd(CMD_INCR, DISABLE_VAL);
    add_cmd(CMD_INCR_CATCHUP, 32'd5);
    add_cmd(CMD_SET, DISABLE_VAL);
    add_cmd(CMD_INCR, 32'd7);
    add_cmd(CMD_INCR_CATCHUP, CATCHUP_LIMIT);
    add_cmd(CMD_INCR_CATCHUP, CATCHUP_LIMIT - 32'd1);
    add_cmd(CMD_INCR_CATCHUP, 32'h8000_0000);
    add_cmd(CMD_RESTART, 32'h0000_0000);
    add_cmd(CMD_SET, 32'h8000_0000);
    add_cmd(CMD_TICK, 32'h0000_0000);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) add_cmd(3'(c), DISABLE_VAL);
    add_cmd(CMD_SET, 32'hFFFF_FFFF);
    add_cmd(CMD_TICK, 32'h0000_0000);
    while (command_q.size() < RANDOM_ITEMS + 24) add_episode();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (command_q.size() != 0 || in_valid || timer_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks, %0d sets, %0d restarts, %0d increments, %0d catch-up %s",
             cmd_seen[CMD_TICK], cmd_seen[CMD_SET], cmd_seen[CMD_RESTART],
             cmd_seen[CMD_INCR], cmd_seen[CMD_INCR_CATCHUP], "increments");
    $display("%0d results checked: %0d catch-up jumps, %0d disabled, %0d timed out, %s",
             results_checked, catchup_jumps, disabled_seen, timed_out_seen,
             $sformatf("%0d unused codes", cmd_seen[5] + cmd_seen[6] + cmd_seen[7]));
    if (errors == 0) begin
      $display("interval_timer_with_catchup verification clean");
    end else begin
      $display("interval_timer_with_catchup verification failed");
    end
    $finish;
  end

  // Sender: bursts of transactions separated by random gaps; the model is
  // advanced on every accepted command.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        timer_reports_q.push_back(timer_apply(in_data));
        cmd_seen[in_data.command]++;
      end
      if (in_valid && !in_ready) begin
        // Hold the transaction until it is taken.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (command_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= command_q.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transaction and stalls in changing patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (timer_reports_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
        end else begin
          report_head = timer_reports_q.pop_front();
          results_checked++;
          check_field("elapsed", report_head.elapsed, out_data.elapsed);
          check_field("expired_by", report_head.expired_by, out_data.expired_by);
          check_field("remaining", report_head.remaining, out_data.remaining);
          check_field("timing", report_head.timing, out_data.timing);
          check_field("disabled", report_head.disabled, out_data.disabled);
        end
      end
      if (stall_phase <= 0) begin
        stall_mode  = rx_mode_t'($urandom_range(0, 3));
        stall_phase = $urandom_range(16, 96);
      end
      stall_phase--;
      case (stall_mode)
        RX_STREAM: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d commands unsent and %0d results missing",
               $time, command_q.size(), timer_reports_q.size());
      $display("interval_timer_with_catchup verification failed");
      $finish;
    end
  end

endmodule
